// ===== design/brts_pkg.sv =====
// ----------------------------------------------------------------------------
// brts_pkg
// Shared types and constants of the bilinear RGB texture sampler: item
// structs, request codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package brts_pkg;

	// parameter defaults
	localparam int DEF_MAX_COLS     = 256;
	localparam int DEF_MAX_ROWS     = 256;
	localparam int DEF_FRAC_BITS    = 8;
	localparam int DEF_CHANNEL_BITS = 16;

	// fixed field widths
	localparam int COORD_BITS    = 16;
	localparam int CHAN_IN_BITS  = 16;
	localparam int CHAN_OUT_BITS = 16;
	localparam int CFG_BITS      = 9;
	localparam int CFG_RESET     = 256;
	localparam int APB_DW        = 32;
	localparam int PADDR_W       = 3;

	// store organization: even/odd column times even/odd row
	localparam int NUM_BANKS = 4;
	localparam int NUM_CHAN  = 3;

	// request codes
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// register indexes (address bit 2)
	typedef enum logic {
		REG_COLS = 1'b0,
		REG_ROWS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                    req_type;
		logic [7:0]              texel_col;
		logic [7:0]              texel_row;
		logic [CHAN_IN_BITS-1:0] texel_red;
		logic [CHAN_IN_BITS-1:0] texel_green;
		logic [CHAN_IN_BITS-1:0] texel_blue;
		logic [COORD_BITS-1:0]   coord_x;
		logic [COORD_BITS-1:0]   coord_y;
	} req_item_t;

	typedef struct packed {
		logic [CHAN_OUT_BITS-1:0] red;
		logic [CHAN_OUT_BITS-1:0] green;
		logic [CHAN_OUT_BITS-1:0] blue;
		logic                     coord_clamped;
	} res_item_t;

endpackage

`default_nettype wire

// ===== design/bilinear_rgb_texture_sampler_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_rgb_texture_sampler_top
// Pipeline: a sample item taken into the input register passes the bank
// read, horizontal lerps and vertical lerp into the output register; the
// address split sits ahead of the input register.
// Throughput: 1 item per cycle while the result channel is not stalled,
// set by the four-bank texel store whose banks each give one read per cycle; write items retire from stage 1.
// Reset: valid bits clear, grid registers return to 256; the texel store
// is not cleared and holds no defined value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_rgb_texture_sampler_top import brts_pkg::*; #(
	parameter int MAX_COLS     = DEF_MAX_COLS,
	parameter int MAX_ROWS     = DEF_MAX_ROWS,
	parameter int FRAC_BITS    = DEF_FRAC_BITS,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [APB_DW-1:0]  pwdata,
	output logic      [APB_DW-1:0]  prdata,
	output logic                    pready,
	// request channel
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_item_t          req_item,
	// result channel
	output logic                    res_valid,
	input  wire logic               res_stall,
	output res_item_t               res_item
);

	localparam int CB  = CHANNEL_BITS;
	localparam int FB  = FRAC_BITS;
	localparam int DW  = NUM_CHAN * CB;
	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CHW = (CW > 1) ? CW - 1 : 1;
	localparam int RHW = (RW > 1) ? RW - 1 : 1;
	localparam int AW  = CHW + RHW;
	localparam int MCW = CW + FB;
	localparam int MRW = RW + FB;
	localparam int CCW = (MCW > COORD_BITS) ? MCW : COORD_BITS;
	localparam int RCW = (MRW > COORD_BITS) ? MRW : COORD_BITS;
	localparam int GCW = ($clog2(MAX_COLS + 1) > CFG_BITS) ? $clog2(MAX_COLS + 1) : CFG_BITS;
	localparam int GRW = ($clog2(MAX_ROWS + 1) > CFG_BITS) ? $clog2(MAX_ROWS + 1) : CFG_BITS;
	localparam int RST_COL_SIZE = (CFG_RESET > MAX_COLS) ? MAX_COLS : CFG_RESET;
	localparam int RST_ROW_SIZE = (CFG_RESET > MAX_ROWS) ? MAX_ROWS : CFG_RESET;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [CFG_BITS-1:0] cols_q, rows_q;
	logic [MCW-1:0]      col_maxc_q, col_maxc_d;
	logic [MRW-1:0]      row_maxc_q, row_maxc_d;
	logic [GCW-1:0]      cfg_cols;
	logic [GRW-1:0]      cfg_rows;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// grid size saturates to 2..max, kept as the largest coordinate in use
	always_comb begin
		cfg_cols = GCW'(pwdata[CFG_BITS-1:0]);
		if (cfg_cols < GCW'(2)) begin
			cfg_cols = GCW'(2);
		end else if (cfg_cols > GCW'(MAX_COLS)) begin
			cfg_cols = GCW'(MAX_COLS);
		end
		cfg_rows = GRW'(pwdata[CFG_BITS-1:0]);
		if (cfg_rows < GRW'(2)) begin
			cfg_rows = GRW'(2);
		end else if (cfg_rows > GRW'(MAX_ROWS)) begin
			cfg_rows = GRW'(MAX_ROWS);
		end
		col_maxc_d = {CW'(cfg_cols - GCW'(1)), {FB{1'b0}}};
		row_maxc_d = {RW'(cfg_rows - GRW'(1)), {FB{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q     <= CFG_BITS'(CFG_RESET);
			rows_q     <= CFG_BITS'(CFG_RESET);
			col_maxc_q <= {CW'(RST_COL_SIZE - 1), {FB{1'b0}}};
			row_maxc_q <= {RW'(RST_ROW_SIZE - 1), {FB{1'b0}}};
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_COLS: begin
					cols_q     <= pwdata[CFG_BITS-1:0];
					col_maxc_q <= col_maxc_d;
				end
				REG_ROWS: begin
					rows_q     <= pwdata[CFG_BITS-1:0];
					row_maxc_q <= row_maxc_d;
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_COLS: prdata = APB_DW'(cols_q);
			REG_ROWS: prdata = APB_DW'(rows_q);
		endcase
	end

	// ------------------------------------------------------------------
	// pipeline control
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic sample_s1;
	logic en_s1, en_s2, en_s3, en_s4, leave_s1, rd_en;

	assign en_s4    = !res_valid || !res_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign leave_s1 = v_s1 && (!sample_s1 || en_s2);
	assign en_s1    = !v_s1 || leave_s1;
	assign req_stall = !en_s1;
	assign rd_en    = v_s1 && sample_s1 && en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= req_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1 && sample_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				res_valid <= v_s3;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 0: coordinate split and bank addresses
	// ------------------------------------------------------------------
	logic [CCW-1:0] cx_ext, cx_sat;
	logic [RCW-1:0] cy_ext, cy_sat;
	logic           clx_d, cly_d;
	logic [CW-1:0]  x0;
	logic [RW-1:0]  y0;
	logic [CW:0]    x0e, x1e, col_even, col_odd;
	logic [RW:0]    y0e, y1e, row_even, row_odd;
	logic [FB-1:0]  fx_d, fy_d;
	logic [AW-1:0]  raddr_d [NUM_BANKS];
	logic [CW-1:0]  wcol;
	logic [RW-1:0]  wrow;
	logic [CW:0]    wcol_e;
	logic [RW:0]    wrow_e;
	logic           wok_d;

	always_comb begin
		// saturate to the last grid position
		cx_ext = CCW'(req_item.coord_x);
		clx_d  = cx_ext > CCW'(col_maxc_q);
		cx_sat = clx_d ? CCW'(col_maxc_q) : cx_ext;
		cy_ext = RCW'(req_item.coord_y);
		cly_d  = cy_ext > RCW'(row_maxc_q);
		cy_sat = cly_d ? RCW'(row_maxc_q) : cy_ext;

		x0   = CW'(cx_sat >> FB);
		y0   = RW'(cy_sat >> FB);
		fx_d = cx_sat[FB-1:0];
		fy_d = cy_sat[FB-1:0];

		// neighbor +1 lands in the other parity bank; where it runs off the
		// grid its weight is zero, so its contents never matter
		x0e      = {1'b0, x0};
		x1e      = x0e + (CW+1)'(1);
		col_even = x0[0] ? x1e : x0e;
		col_odd  = x0[0] ? x0e : x1e;
		y0e      = {1'b0, y0};
		y1e      = y0e + (RW+1)'(1);
		row_even = y0[0] ? y1e : y0e;
		row_odd  = y0[0] ? y0e : y1e;

		for (int k = 0; k < NUM_BANKS; k++) begin
			raddr_d[k] = {k[1] ? row_odd[RHW:1] : row_even[RHW:1],
			              k[0] ? col_odd[CHW:1] : col_even[CHW:1]};
		end

		// texel write position
		wcol   = CW'(req_item.texel_col);
		wrow   = RW'(req_item.texel_row);
		wcol_e = {1'b0, wcol};
		wrow_e = {1'b0, wrow};
		wok_d  = (int'(req_item.texel_col) < MAX_COLS) &&
		         (int'(req_item.texel_row) < MAX_ROWS);
	end

	// ------------------------------------------------------------------
	// stage 1 registers
	// ------------------------------------------------------------------
	logic [AW-1:0] raddr_s1 [NUM_BANKS];
	logic [AW-1:0] waddr_s1;
	logic [1:0]    wbank_s1;
	logic [DW-1:0] wdata_s1;
	logic          wok_s1;
	logic [FB-1:0] fx_s1, fy_s1;
	logic          xpar_s1, ypar_s1, clx_s1, cly_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sample_s1 <= (req_item.req_type == REQ_SAMPLE);
			raddr_s1  <= raddr_d;
			waddr_s1  <= {wrow_e[RHW:1], wcol_e[CHW:1]};
			wbank_s1  <= {wrow[0], wcol[0]};
			wdata_s1  <= {CB'(req_item.texel_red), CB'(req_item.texel_green),
			              CB'(req_item.texel_blue)};
			wok_s1    <= wok_d;
			fx_s1     <= fx_d;
			fy_s1     <= fy_d;
			xpar_s1   <= x0[0];
			ypar_s1   <= y0[0];
			clx_s1    <= clx_d;
			cly_s1    <= cly_d;
		end
	end

	// ------------------------------------------------------------------
	// texel store: four banks by row and column parity
	// ------------------------------------------------------------------
	logic [NUM_BANKS-1:0] we;
	logic [DW-1:0]        rd_s2 [NUM_BANKS];

	always_comb begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			we[k] = v_s1 && !sample_s1 && wok_s1 && (wbank_s1 == 2'(k));
		end
	end

	genvar gk;
	for (gk = 0; gk < NUM_BANKS; gk++) begin : g_bank
		brts_bank #(
			.DW (DW),
			.AW (AW)
		) u_bank (
			.clk   (clk),
			.we    (we[gk]),
			.waddr (waddr_s1),
			.wdata (wdata_s1),
			.re    (rd_en),
			.raddr (raddr_s1[gk]),
			.rdata (rd_s2[gk])
		);
	end

	// ------------------------------------------------------------------
	// stage 2: pick the four neighbors, lerp along x
	// ------------------------------------------------------------------
	logic [FB-1:0] fx_s2, fy_s2;
	logic          xpar_s2, ypar_s2, clamp_s2;
	logic [1:0]    i00, i01, i10, i11;
	logic [CB-1:0] top_d [NUM_CHAN];
	logic [CB-1:0] bot_d [NUM_CHAN];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			fx_s2    <= fx_s1;
			fy_s2    <= fy_s1;
			xpar_s2  <= xpar_s1;
			ypar_s2  <= ypar_s1;
			clamp_s2 <= clx_s1 || cly_s1;
		end
	end

	assign i00 = {ypar_s2, xpar_s2};
	assign i01 = {ypar_s2, !xpar_s2};
	assign i10 = {!ypar_s2, xpar_s2};
	assign i11 = {!ypar_s2, !xpar_s2};

	// ------------------------------------------------------------------
	// stage 3: lerp along y
	// ------------------------------------------------------------------
	logic [CB-1:0] top_s3 [NUM_CHAN];
	logic [CB-1:0] bot_s3 [NUM_CHAN];
	logic [FB-1:0] fy_s3;
	logic          clamp_s3;
	logic [CB-1:0] out_d [NUM_CHAN];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			top_s3   <= top_d;
			bot_s3   <= bot_d;
			fy_s3    <= fy_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	genvar gc;
	for (gc = 0; gc < NUM_CHAN; gc++) begin : g_chan
		localparam int LSB = (NUM_CHAN - 1 - gc) * CB;

		brts_lerp #(.CB(CB), .FB(FB)) u_top (
			.a (rd_s2[i00][LSB +: CB]),
			.b (rd_s2[i01][LSB +: CB]),
			.f (fx_s2),
			.y (top_d[gc])
		);

		brts_lerp #(.CB(CB), .FB(FB)) u_bot (
			.a (rd_s2[i10][LSB +: CB]),
			.b (rd_s2[i11][LSB +: CB]),
			.f (fx_s2),
			.y (bot_d[gc])
		);

		brts_lerp #(.CB(CB), .FB(FB)) u_vert (
			.a (top_s3[gc]),
			.b (bot_s3[gc]),
			.f (fy_s3),
			.y (out_d[gc])
		);
	end

	// ------------------------------------------------------------------
	// stage 4: output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en_s4) begin
			res_item.red           <= CHAN_OUT_BITS'(out_d[0]);
			res_item.green         <= CHAN_OUT_BITS'(out_d[1]);
			res_item.blue          <= CHAN_OUT_BITS'(out_d[2]);
			res_item.coord_clamped <= clamp_s3;
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// a saturated coordinate sits on a grid point, so its fraction is zero
	a_clamp_x_frac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && sample_s1 && clx_s1 |-> fx_s1 == '0)
		else $error("clamped x coordinate carries a fraction");

	a_clamp_y_frac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && sample_s1 && cly_s1 |-> fy_s1 == '0)
		else $error("clamped y coordinate carries a fraction");

	// a blocked stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en_s4 |=> v_s3 && $stable(top_s3[0]) && $stable(fy_s3))
		else $error("stage 3 item lost under stall");

	// input stalls only when every stage holds an item and the output waits
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> v_s1 && sample_s1 && v_s2 && v_s3 && res_valid && res_stall)
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== design/brts_bank.sv =====
// ----------------------------------------------------------------------------
// brts_bank
// One bank of the texel store: one write port, one read port with a
// registered read data output that holds while read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module brts_bank #(
	parameter int DW = 48,
	parameter int AW = 14
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [1 << AW];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/brts_lerp.sv =====
// ----------------------------------------------------------------------------
// brts_lerp
// Fixed-point linear interpolation a + floor(f * (b - a) / 2^FB), done with
// one signed multiply and an add. The far operand is dropped when its
// weight is zero so that a don't-care texel cannot reach the result.
// ----------------------------------------------------------------------------
`default_nettype none

module brts_lerp import brts_pkg::*; #(
	parameter int CB = DEF_CHANNEL_BITS,
	parameter int FB = DEF_FRAC_BITS
) (
	input  wire logic [CB-1:0] a,
	input  wire logic [CB-1:0] b,
	input  wire logic [FB-1:0] f,
	output logic      [CB-1:0] y
);

	localparam int PW = CB + FB + 2;

	logic        [CB-1:0] b_use;
	logic signed [CB:0]   diff;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] base;
	logic signed [PW-1:0] sum;

	// zero weight means the result is exactly a
	assign b_use = (f == '0) ? '0 : b;
	assign diff  = $signed({1'b0, b_use}) - $signed({1'b0, a});
	assign prod  = $signed({1'b0, f}) * diff;
	assign base  = $signed({2'b00, a, {FB{1'b0}}});
	assign sum   = base + prod;

	// sum stays between a and b scaled, so it is never negative
	assign y = sum[FB +: CB];

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear RGB texture sampler. Texel writes and
// sample items are queued per phase, each phase under its own grid size;
// every texel a sample touches is written first. A predictor inside the bench
// blends the four neighbors of each accepted sample and the monitor checks
// the results in order, while both channels idle at random in the early phases.
// ----------------------------------------------------------------------------

module testbench import brts_pkg::*; ();

	localparam int FRAC_ONE    = 1 << DEF_FRAC_BITS;
	localparam int STORE_DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS;
	localparam int NUM_PHASES  = 10;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} texel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	// predictor copy of grid registers and texel store
	logic [CFG_BITS-1:0] cols_cfg = CFG_BITS'(CFG_RESET);
	logic [CFG_BITS-1:0] rows_cfg = CFG_BITS'(CFG_RESET);
	texel_t              texel_mem [0:STORE_DEPTH-1];

	// stimulus side bookkeeping of which texels hold data
	bit texel_loaded [0:STORE_DEPTH-1];

	req_item_t req_backlog [$];
	res_item_t pixel_due [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;

	bilinear_rgb_texture_sampler_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always #10 clk = ~clk;

	// grid size as used by the block: register saturated to 2..max
	function automatic int unsigned grid_size(input logic [CFG_BITS-1:0] r, input int unsigned max);
		int unsigned v;
		v = r;
		if (v < 2) v = 2;
		if (v > max) v = max;
		return v;
	endfunction

	// saturate one coordinate, split into index, +1 index and fraction
	function automatic bit split_axis(input int unsigned c, input int unsigned size,
			output int unsigned lo, output int unsigned hi, output int unsigned frac);
		int unsigned maxc;
		bit clamped;
		maxc = (size - 1) << DEF_FRAC_BITS;
		clamped = 1'b0;
		if (c > maxc) begin
			c = maxc;
			clamped = 1'b1;
		end
		lo = c >> DEF_FRAC_BITS;
		frac = c & (FRAC_ONE - 1);
		hi = (lo + 1 < size) ? lo + 1 : size - 1;
		return clamped;
	endfunction

	function automatic logic [15:0] blend(input int unsigned a, input int unsigned b,
			input int unsigned f);
		int unsigned s;
		s = (a * (FRAC_ONE - f) + b * f) >> DEF_FRAC_BITS;
		return s[15:0];
	endfunction

	// expected result of one sample item under the current grid
	function automatic res_item_t sample_texels(input req_item_t it);
		int unsigned x0, x1, fx, y0, y1, fy;
		bit cx, cy;
		texel_t t00, t01, t10, t11;
		res_item_t r;
		cx = split_axis(it.coord_x, grid_size(cols_cfg, DEF_MAX_COLS), x0, x1, fx);
		cy = split_axis(it.coord_y, grid_size(rows_cfg, DEF_MAX_ROWS), y0, y1, fy);
		t00 = texel_mem[y0 * DEF_MAX_COLS + x0];
		t01 = texel_mem[y0 * DEF_MAX_COLS + x1];
		t10 = texel_mem[y1 * DEF_MAX_COLS + x0];
		t11 = texel_mem[y1 * DEF_MAX_COLS + x1];
		r.red   = blend(blend(t00.red, t01.red, fx), blend(t10.red, t11.red, fx), fy);
		r.green = blend(blend(t00.green, t01.green, fx), blend(t10.green, t11.green, fx), fy);
		r.blue  = blend(blend(t00.blue, t01.blue, fx), blend(t10.blue, t11.blue, fx), fy);
		r.coord_clamped = cx | cy;
		return r;
	endfunction

	// channel value biased toward the extremes
	function automatic logic [15:0] pick_chan();
		int unsigned k;
		k = $urandom_range(0, 7);
		if (k == 0) return 16'h0000;
		if (k == 1) return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic texel_t pick_texel();
		texel_t t;
		t.red = pick_chan();
		t.green = pick_chan();
		t.blue = pick_chan();
		return t;
	endfunction

	// coordinate on one axis: mostly inside the grid, some at the edge, some anywhere
	function automatic logic [15:0] pick_coord(input int unsigned size);
		int unsigned k, maxc;
		maxc = (size - 1) << DEF_FRAC_BITS;
		k = $urandom_range(0, 99);
		if (k < 50) return 16'($urandom_range(0, maxc));
		if (k < 70) return 16'(maxc - 1 + $urandom_range(0, 2));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic push_write(input int unsigned col, input int unsigned row, input texel_t v);
		req_item_t it;
		it.req_type = REQ_WRITE;
		it.texel_col = 8'(col);
		it.texel_row = 8'(row);
		it.texel_red = v.red;
		it.texel_green = v.green;
		it.texel_blue = v.blue;
		it.coord_x = 16'($urandom_range(0, 65535));
		it.coord_y = 16'($urandom_range(0, 65535));
		req_backlog.push_back(it);
		texel_loaded[row * DEF_MAX_COLS + col] = 1'b1;
	endtask

	task automatic load_if_empty(input int unsigned col, input int unsigned row);
		if (!texel_loaded[row * DEF_MAX_COLS + col])
			push_write(col, row, pick_texel());
	endtask

	// sample item, preceded by writes of any neighbor not yet loaded
	task automatic push_sample(input logic [15:0] x, input logic [15:0] y);
		int unsigned x0, x1, fx, y0, y1, fy;
		bit c;
		req_item_t it;
		c = split_axis(x, grid_size(cols_cfg, DEF_MAX_COLS), x0, x1, fx);
		c = split_axis(y, grid_size(rows_cfg, DEF_MAX_ROWS), y0, y1, fy);
		load_if_empty(x0, y0);
		load_if_empty(x1, y0);
		load_if_empty(x0, y1);
		load_if_empty(x1, y1);
		it.req_type = REQ_SAMPLE;
		it.texel_col = 8'($urandom_range(0, 255));
		it.texel_row = 8'($urandom_range(0, 255));
		it.texel_red = 16'($urandom_range(0, 65535));
		it.texel_green = 16'($urandom_range(0, 65535));
		it.texel_blue = 16'($urandom_range(0, 65535));
		it.coord_x = x;
		it.coord_y = y;
		req_backlog.push_back(it);
	endtask

	// register write then readback over the configuration port
	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_BITS-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & 32'hFFFF_FE00) | APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_COLS) cols_cfg = val;
		else rows_cfg = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(APB_DW - CFG_BITS){1'b0}}, val}) begin
			$error("prdata: expected %0h, actual %0h", val, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// driver: predict accepted items, offer the next pending one
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				if (req_item.req_type == REQ_WRITE)
					texel_mem[req_item.texel_row * DEF_MAX_COLS + req_item.texel_col] =
						{req_item.texel_red, req_item.texel_green, req_item.texel_blue};
				else
					pixel_due.push_back(sample_texels(req_item));
			end
			if (!req_valid || !req_stall) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_item <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (pixel_due.size() == 0) begin
					$error("result item with no sample outstanding");
					mismatches++;
				end else begin
					res_item_t want;
					want = pixel_due.pop_front();
					if (res_item.red !== want.red) begin
						$error("red: expected %0h, actual %0h", want.red, res_item.red);
						mismatches++;
					end
					if (res_item.green !== want.green) begin
						$error("green: expected %0h, actual %0h", want.green, res_item.green);
						mismatches++;
					end
					if (res_item.blue !== want.blue) begin
						$error("blue: expected %0h, actual %0h", want.blue, res_item.blue);
						mismatches++;
					end
					if (res_item.coord_clamped !== want.coord_clamped) begin
						$error("coord_clamped: expected %0b, actual %0b",
							want.coord_clamped, res_item.coord_clamped);
						mismatches++;
					end
				end
			end
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// stimulus phases
	initial begin
		int cols_set [NUM_PHASES];
		int rows_set [NUM_PHASES];
		int unsigned cols, rows, start;
		int k;
		cols_set = '{256, 2, 511, 1, 17, 256, 3, 0, 0, 256};
		rows_set = '{256, 2, 0, 257, 5, 256, 130, 0, 0, 2};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			// sender idles lightly then receiver hard, swapped, then no idling
			if (p < 4) begin
				send_idle_pct = 7;
				recv_idle_pct = 67;
			end else if (p < 7) begin
				send_idle_pct = 67;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 7) begin
				cols_set[p] = $urandom_range(2, 256);
				rows_set[p] = $urandom_range(2, 256);
			end else if (p == 8) begin
				cols_set[p] = $urandom_range(0, 511);
				rows_set[p] = $urandom_range(0, 511);
			end
			cfg_write(REG_COLS, CFG_BITS'(cols_set[p]));
			cfg_write(REG_ROWS, CFG_BITS'(rows_set[p]));
			cols = grid_size(cols_cfg, DEF_MAX_COLS);
			rows = grid_size(rows_cfg, DEF_MAX_ROWS);
			if (p == 0) begin
				// corner texels at the channel extremes, one rewritten
				push_write(0, 0, '0);
				push_write(1, 0, '1);
				push_write(0, 1, '1);
				push_write(1, 1, {16'h1234, 16'h0000, 16'hFFFF});
				push_write(1, 1, '0);
				push_write(254, 254, {16'hFFFF, 16'h0000, 16'h8000});
				push_write(255, 254, {16'h0000, 16'hFFFF, 16'h7FFF});
				push_write(254, 255, '1);
				push_write(255, 255, {16'hFFFF, 16'hFFFF, 16'h0000});
				// exact, mid and full fractions; last index; beyond the grid
				push_sample(16'h0000, 16'h0000);
				push_sample(16'h0080, 16'h0040);
				push_sample(16'h00FF, 16'h00FF);
				push_sample(16'hFEFF, 16'hFEFF);
				push_sample(16'hFF00, 16'hFF00);
				push_sample(16'hFFFF, 16'hFFFF);
				push_sample(16'hFF01, 16'h0000);
				push_sample(16'h0000, 16'hFF01);
				push_sample(16'h7F80, 16'h3FC0);
			end else begin
				start = req_backlog.size();
				while (req_backlog.size() - start < 83) begin
					k = $urandom_range(0, 99);
					if (k < 70)
						push_sample(pick_coord(cols), pick_coord(rows));
					else if (k < 85)
						push_write($urandom_range(0, 255), $urandom_range(0, 255), pick_texel());
					else
						push_write($urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
							pick_texel());
				end
			end
			// drain before touching the registers again; checked on the falling
			// edge so the driver and monitor updates of this cycle are settled
			do @(negedge clk); while (req_backlog.size() != 0 || req_valid || pixel_due.size() != 0);
			repeat (12) @(posedge clk);
		end
		if (mismatches == 0 && pixel_due.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
